// ===== rtl/vsp_pkg.sv =====
// package: request/result types and constants for the vsp operating mode core
`default_nettype none
package vsp_pkg;

    localparam int MODE_COUNT_DEF = 41;
    localparam int CAT_COUNT      = 6;

    // register indexes
    localparam logic [2:0] REG_ROLLING  = 3'd0;
    localparam logic [2:0] REG_ROTATION = 3'd1;
    localparam logic [2:0] REG_DRAG     = 3'd2;
    localparam logic [2:0] REG_MASS     = 3'd3;
    localparam logic [2:0] REG_INV_MASS = 3'd4;
    localparam logic [2:0] REG_GRADE    = 3'd5;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    // operating modes
    localparam logic [5:0] MODE_BRAKE = 6'd0;
    localparam logic [5:0] MODE_IDLE  = 6'd1;

    // round(2.23693629 * 2^24), m/s to mph
    localparam logic [39:0] MPH_K = 40'd37529563;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] speed_sample;
        logic [5:0]         load_mode;
        logic [2:0]         load_category;
        logic [31:0]        load_rate;
    } vsp_in_t;

    typedef struct packed {
        logic [5:0]         op_mode;
        logic signed [31:0] vsp_value;
        logic signed [15:0] accel_value;
        logic [31:0]        rate_hc;
        logic [31:0]        rate_co;
        logic [31:0]        rate_nox;
        logic [31:0]        rate_co2;
        logic [31:0]        rate_energy;
        logic [31:0]        rate_pm;
    } vsp_out_t;

    // vsp band split, vsp in signed Q24.8
    function automatic logic [5:0] vsp_bin(input logic signed [31:0] q,
                                           input logic signed [47:0] sp,
                                           input logic signed [47:0] ac);
        logic signed [47:0] unit;
        logic [5:0]         m;
        begin
            unit = 48'sh0001_0000_0000;
            if (ac <= -(unit <<< 1)) begin
                m = MODE_BRAKE;
            end else if (sp < unit && sp >= -unit) begin
                m = MODE_IDLE;
            end else if (sp < 25 * unit && sp >= 0) begin
                if (q < 0)               m = 6'd11;
                else if (q < 3 * 256)    m = 6'd12;
                else if (q < 6 * 256)    m = 6'd13;
                else if (q < 9 * 256)    m = 6'd14;
                else if (q < 12 * 256)   m = 6'd15;
                else                     m = 6'd16;
            end else if (sp < 50 * unit) begin
                if (q < 0)               m = 6'd21;
                else if (q < 3 * 256)    m = 6'd22;
                else if (q < 6 * 256)    m = 6'd23;
                else if (q < 9 * 256)    m = 6'd24;
                else if (q < 12 * 256)   m = 6'd25;
                else if (q < 18 * 256)   m = 6'd27;
                else if (q < 24 * 256)   m = 6'd28;
                else if (q < 30 * 256)   m = 6'd29;
                else                     m = 6'd30;
            end else begin
                if (q < 6 * 256)         m = 6'd33;
                else if (q < 12 * 256)   m = 6'd35;
                else if (q < 18 * 256)   m = 6'd37;
                else if (q < 24 * 256)   m = 6'd38;
                else if (q < 30 * 256)   m = 6'd39;
                else                     m = 6'd40;
            end
            return m;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vsp_opmode_emission_rate_core.sv =====
// top level: vsp computation, mode binning and emission rate table lookup
// sequence: a speed sample that yields a result passes from accept to m_valid through
//   11 steps of the one shared 40x33 multiplier, 1 saturation step, 1 binning step,
//   reads of the six rate words over the single read port, and the output register
// accept: s_ready is high only while idle, so a new sample waits until the last result
//   is registered (longer while m_data waits for m_ready); loads and warm-up stay idle
// reset: synchronous active low aresetn clears control, config and history; the rate
//   table is not cleared and reads undefined until written
`default_nettype none
module vsp_opmode_emission_rate_core
    import vsp_pkg::*;
#(
    parameter int MODE_COUNT = MODE_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire vsp_in_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output vsp_out_t         m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int DEPTH = MODE_COUNT * CAT_COUNT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_READ, ST_OUT} state_t;

    state_t state_reg;
    logic [3:0] step_reg;
    logic [2:0] rd_cnt_reg;

    // configuration
    logic [31:0] coef_a_reg, coef_b_reg, coef_c_reg, mass_reg, inv_f_reg;
    logic signed [31:0] grade_reg;

    // sample history
    logic signed [15:0] sw0_reg, sw1_reg, hist0_reg, hist1_reg;
    logic [1:0]         warm_reg;

    // working registers
    logic signed [15:0] v_reg, a_reg;
    logic [30:0]        v2_reg;
    logic [37:0]        cv2_reg;
    logic signed [33:0] mm_reg;
    logic signed [47:0] acc_reg, sp_reg, ac_reg;
    logic [46:0]        mag_reg;
    logic               neg_reg;
    logic [55:0]        x_reg;
    logic [56:0]        y_reg;
    logic signed [31:0] vsp_reg;
    logic [5:0]         mode_reg;
    logic [AW-1:0]      base_reg;
    logic [31:0]        rate_reg [CAT_COUNT];
    logic [31:0]        rdata_reg;

    vsp_out_t m_data_reg;
    logic     m_valid_reg;

    // rate table
    logic [31:0] mem [DEPTH];

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // acceleration of the middle sample
    logic signed [16:0] diff;
    assign diff = 17'(s_data.speed_sample) - 17'(sw0_reg);

    // a*2^16 + grade, floored to Q.16
    logic signed [32:0] ag;
    logic signed [24:0] agf;
    assign ag  = {a_reg[15], a_reg, 16'b0} + 33'(grade_reg);
    assign agf = ag[32:8];

    // shared multiplier operand select
    logic signed [39:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [72:0] prod;
    always_comb begin
        mul_a = 40'(v_reg);
        mul_b = 33'(v_reg);
        case (step_reg)
            4'd0: begin mul_a = 40'(v_reg);                 mul_b = 33'(v_reg); end
            4'd1: begin mul_a = {8'b0, coef_a_reg};         mul_b = 33'(v_reg); end
            4'd2: begin mul_a = {8'b0, coef_b_reg};         mul_b = {2'b0, v2_reg}; end
            4'd3: begin mul_a = {8'b0, coef_c_reg};         mul_b = {2'b0, v2_reg}; end
            4'd4: begin mul_a = {2'b0, cv2_reg};            mul_b = 33'(v_reg); end
            4'd5: begin mul_a = {8'b0, mass_reg};           mul_b = 33'(agf); end
            4'd6: begin mul_a = 40'(mm_reg);                mul_b = 33'(v_reg); end
            4'd7: begin mul_a = MPH_K;                      mul_b = 33'(v_reg); end
            4'd8: begin mul_a = MPH_K;                      mul_b = 33'(a_reg); end
            4'd9: begin mul_a = {17'b0, mag_reg[46:24]};    mul_b = {1'b0, inv_f_reg}; end
            4'd10: begin mul_a = {16'b0, mag_reg[23:0]};    mul_b = {1'b0, inv_f_reg}; end
            default: begin mul_a = 40'(v_reg);              mul_b = 33'(v_reg); end
        endcase
    end
    assign prod = 73'(mul_a) * 73'(mul_b);

    // product to Q.8 magnitude and saturation
    logic [57:0] low_sum;
    logic [48:0] r;
    logic signed [31:0] vsp_sat;
    assign low_sum = {26'b0, x_reg[7:0], 24'b0} + {1'b0, y_reg};
    assign r = {1'b0, x_reg[55:8]} + {23'b0, low_sum[57:32]};
    always_comb begin
        if (!neg_reg) begin
            vsp_sat = (r > 49'd2147483647) ? 32'sh7fff_ffff : 32'(r);
        end else if (r >= 49'd2147483648) begin
            vsp_sat = 32'sh8000_0000;
        end else begin
            vsp_sat = -32'(r);
        end
    end

    // mode with sustained braking override
    logic [5:0] mode_bin;
    always_comb begin
        mode_bin = vsp_bin(vsp_reg, sp_reg, ac_reg);
        if (hist0_reg < -16'sd256 && hist1_reg < -16'sd256 && a_reg < -16'sd256) begin
            mode_bin = MODE_BRAKE;
        end
    end

    logic s_fire, load_ok;
    assign s_fire  = s_valid && s_ready;
    assign load_ok = ({1'b0, s_data.load_mode} < 7'(MODE_COUNT)) &&
                     (s_data.load_category < 3'(CAT_COUNT));

    // table write on load, registered read
    logic [AW-1:0] wr_addr, rd_addr;
    assign wr_addr = AW'(s_data.load_mode) * AW'(CAT_COUNT) + AW'(s_data.load_category);
    assign rd_addr = base_reg + AW'(rd_cnt_reg);
    always_ff @(posedge aclk) begin
        if (s_fire && s_data.req_type == REQ_LOAD && load_ok) begin
            mem[wr_addr] <= s_data.load_rate;
        end
        rdata_reg <= mem[rd_addr];
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_c_reg <= '0;
            mass_reg   <= '0;
            inv_f_reg  <= 32'h0100_0000;
            grade_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ROLLING:  coef_a_reg <= cfg_data;
                REG_ROTATION: coef_b_reg <= cfg_data;
                REG_DRAG:     coef_c_reg <= cfg_data;
                REG_MASS:     mass_reg   <= cfg_data;
                REG_INV_MASS: inv_f_reg  <= cfg_data;
                REG_GRADE:    grade_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            rd_cnt_reg  <= '0;
            warm_reg    <= '0;
            sw0_reg     <= '0;
            sw1_reg     <= '0;
            hist0_reg   <= '0;
            hist1_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire && s_data.req_type == REQ_SAMPLE) begin
                        sw0_reg <= sw1_reg;
                        sw1_reg <= s_data.speed_sample;
                        if (warm_reg < 2'd2) begin
                            warm_reg <= warm_reg + 2'd1;
                        end else begin
                            v_reg     <= sw1_reg;
                            a_reg     <= diff[16:1];
                            acc_reg   <= '0;
                            step_reg  <= '0;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    step_reg <= step_reg + 4'd1;
                    case (step_reg)
                        4'd0: v2_reg  <= prod[30:0];
                        4'd1: acc_reg <= acc_reg + prod[63:16];
                        4'd2: acc_reg <= acc_reg + prod[71:24];
                        4'd3: cv2_reg <= prod[61:24];
                        4'd4: acc_reg <= acc_reg + prod[55:8];
                        4'd5: mm_reg  <= prod[57:24];
                        4'd6: acc_reg <= acc_reg + prod[55:8];
                        4'd7: begin
                            sp_reg  <= prod[47:0];
                            neg_reg <= acc_reg[47];
                            mag_reg <= acc_reg[47] ? 47'(-acc_reg) : acc_reg[46:0];
                        end
                        4'd8: ac_reg <= prod[47:0];
                        4'd9: x_reg  <= prod[55:0];
                        4'd10: y_reg <= prod[56:0];
                        4'd11: vsp_reg <= vsp_sat;
                        4'd12: begin
                            mode_reg   <= mode_bin;
                            base_reg   <= AW'(mode_bin) * AW'(CAT_COUNT);
                            hist0_reg  <= hist1_reg;
                            hist1_reg  <= a_reg;
                            rd_cnt_reg <= '0;
                            state_reg  <= ST_READ;
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end
                ST_READ: begin
                    rd_cnt_reg <= rd_cnt_reg + 3'd1;
                    if (rd_cnt_reg != 3'd0) begin
                        rate_reg[rd_cnt_reg - 3'd1] <= rdata_reg;
                    end
                    if (rd_cnt_reg == 3'(CAT_COUNT)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg            <= 1'b1;
                        m_data_reg.op_mode     <= mode_reg;
                        m_data_reg.vsp_value   <= vsp_reg;
                        m_data_reg.accel_value <= a_reg;
                        m_data_reg.rate_hc     <= rate_reg[0];
                        m_data_reg.rate_co     <= rate_reg[1];
                        m_data_reg.rate_nox    <= rate_reg[2];
                        m_data_reg.rate_co2    <= rate_reg[3];
                        m_data_reg.rate_energy <= rate_reg[4];
                        m_data_reg.rate_pm     <= rate_reg[5];
                        state_reg              <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== dv/vsp_opmode_emission_rate_core_tb.sv =====
// testbench: vsp operating mode core checked against a built-in mode and rate predictor
`timescale 1ns / 100ps
`default_nettype none
module vsp_opmode_emission_rate_core_tb;
    import vsp_pkg::*;

    localparam int  TABLE_WORDS = MODE_COUNT_DEF * CAT_COUNT;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  IN_W = $bits(vsp_in_t);
    localparam longint MPH_UNIT = 64'sd4294967296;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    vsp_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    vsp_out_t    m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // predictor state
    bit [31:0]   coef [6];
    int          speed_win [2];
    int          accel_hist [2];
    int          warm_count;
    bit [31:0]   rate_tbl [TABLE_WORDS];

    vsp_out_t    pending_modes [$];
    int          errors = 0;
    int          cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          walk_speed = 0;

    vsp_opmode_emission_rate_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("vsp_opmode_emission_rate_core regression: fail");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // vsp in Q24.8 from speed and acceleration
    function automatic int calc_vsp(int v, int a);
        longint          vv, ta, tb, cv2, tc, ag, mt, tm, p;
        longint unsigned v2, rb, dc;
        longint          ca, ms;
        int              g;
        logic [63:0]     mag;
        logic [127:0]    prod;
        logic [95:0]     r;
        begin
            vv = longint'(v);
            v2 = vv * vv;
            ca = longint'(coef[REG_ROLLING]);
            rb = 64'(coef[REG_ROTATION]);
            dc = 64'(coef[REG_DRAG]);
            ms = longint'(coef[REG_MASS]);
            g = coef[REG_GRADE];
            ta = (ca * vv) >>> 16;
            tb = (rb * v2) >> 24;
            cv2 = (dc * v2) >> 24;
            tc = (cv2 * vv) >>> 8;
            ag = longint'(a) * 65536 + longint'(g);
            mt = (ms * (ag >>> 8)) >>> 24;
            tm = (mt * vv) >>> 8;
            p = ta + tb + tc + tm;
            mag = (p < 0) ? -p : p;
            prod = {64'b0, mag} * {96'b0, coef[REG_INV_MASS]};
            r = prod[127:32];
            if (p >= 0) return (r > 96'd2147483647) ? 32'h7fffffff : int'(r);
            if (r >= 96'd2147483648) return 32'h80000000;
            return -int'(r);
        end
    endfunction

    // operating mode bin
    function automatic logic [5:0] calc_mode(int q, int v, int a);
        longint sp, ac;
        begin
            sp = longint'(v) * 37529563;
            ac = longint'(a) * 37529563;
            if (ac <= -2 * MPH_UNIT) return MODE_BRAKE;
            if (sp < MPH_UNIT && sp >= -MPH_UNIT) return MODE_IDLE;
            if (sp < 25 * MPH_UNIT && sp >= 0) begin
                if (q < 0) return 6'd11;
                if (q < 3 * 256) return 6'd12;
                if (q < 6 * 256) return 6'd13;
                if (q < 9 * 256) return 6'd14;
                if (q < 12 * 256) return 6'd15;
                return 6'd16;
            end
            if (sp < 50 * MPH_UNIT) begin
                if (q < 0) return 6'd21;
                if (q < 3 * 256) return 6'd22;
                if (q < 6 * 256) return 6'd23;
                if (q < 9 * 256) return 6'd24;
                if (q < 12 * 256) return 6'd25;
                if (q < 18 * 256) return 6'd27;
                if (q < 24 * 256) return 6'd28;
                if (q < 30 * 256) return 6'd29;
                return 6'd30;
            end
            if (q < 6 * 256) return 6'd33;
            if (q < 12 * 256) return 6'd35;
            if (q < 18 * 256) return 6'd37;
            if (q < 24 * 256) return 6'd38;
            if (q < 30 * 256) return 6'd39;
            return 6'd40;
        end
    endfunction

    // update predictor for one accepted request
    task automatic predict_request(vsp_in_t rq);
        int       s, a, v, base;
        vsp_out_t res;
        begin
            if (rq.req_type == REQ_LOAD) begin
                if (rq.load_mode < MODE_COUNT_DEF && rq.load_category < CAT_COUNT)
                    rate_tbl[rq.load_mode * CAT_COUNT + rq.load_category] = rq.load_rate;
            end else begin
                s = int'(rq.speed_sample);
                if (warm_count < 2) begin
                    warm_count++;
                end else begin
                    a = (s - speed_win[0]) >>> 1;
                    v = speed_win[1];
                    res.vsp_value = calc_vsp(v, a);
                    res.op_mode = calc_mode(res.vsp_value, v, a);
                    if (accel_hist[0] < -256 && accel_hist[1] < -256 && a < -256)
                        res.op_mode = MODE_BRAKE;
                    res.accel_value = a[15:0];
                    base = res.op_mode * CAT_COUNT;
                    res.rate_hc = rate_tbl[base];
                    res.rate_co = rate_tbl[base + 1];
                    res.rate_nox = rate_tbl[base + 2];
                    res.rate_co2 = rate_tbl[base + 3];
                    res.rate_energy = rate_tbl[base + 4];
                    res.rate_pm = rate_tbl[base + 5];
                    pending_modes.push_back(res);
                    accel_hist[0] = accel_hist[1];
                    accel_hist[1] = a;
                end
                speed_win[0] = speed_win[1];
                speed_win[1] = s;
            end
        end
    endtask

    task automatic report_field(string name, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        vsp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_modes.size() == 0) begin
                errors++;
                $display("%0t unexpected result, expected none actual %h", $time, m_data);
            end else begin
                want = pending_modes.pop_front();
                report_field("op_mode", want.op_mode, m_data.op_mode);
                report_field("vsp_value", want.vsp_value, m_data.vsp_value);
                report_field("accel_value", want.accel_value, m_data.accel_value);
                report_field("rate_hc", want.rate_hc, m_data.rate_hc);
                report_field("rate_co", want.rate_co, m_data.rate_co);
                report_field("rate_nox", want.rate_nox, m_data.rate_nox);
                report_field("rate_co2", want.rate_co2, m_data.rate_co2);
                report_field("rate_energy", want.rate_energy, m_data.rate_energy);
                report_field("rate_pm", want.rate_pm, m_data.rate_pm);
            end
        end
    end

    // send one request, sometimes after a random gap
    task automatic send_request(vsp_in_t rq);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= rq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(rq);
    endtask

    task automatic send_speed(int spd);
        vsp_in_t rq;
        rq = IN_W'({$urandom, $urandom});
        rq.req_type = REQ_SAMPLE;
        rq.speed_sample = spd[15:0];
        send_request(rq);
    endtask

    task automatic send_load(logic [5:0] md, logic [2:0] cat, logic [31:0] val);
        vsp_in_t rq;
        rq.req_type = REQ_LOAD;
        rq.speed_sample = 16'($urandom);
        rq.load_mode = md;
        rq.load_category = cat;
        rq.load_rate = val;
        send_request(rq);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_modes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // register write, block idle
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        coef[idx] = val;
    endtask

    task automatic write_all(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             logic [31:0] m, logic [31:0] f, logic [31:0] g);
        write_reg(REG_ROLLING, a);
        write_reg(REG_ROTATION, b);
        write_reg(REG_DRAG, c);
        write_reg(REG_MASS, m);
        write_reg(REG_INV_MASS, f);
        write_reg(REG_GRADE, g);
    endtask

    // realistic passenger car coefficients
    task automatic write_car_coefs(logic [31:0] g);
        write_all(32'h0028_0000, 32'h0000_8000, 32'h0000_1e00,
                  32'h0180_0000, 32'h00ad_0000, g);
    endtask

    // fill every table word so no result reads an unwritten entry, then out-of-range and extreme loads
    task automatic test_table_load();
        for (int i = 0; i < TABLE_WORDS; i++)
            send_load(6'(i / CAT_COUNT), 3'(i % CAT_COUNT), $urandom);
        send_load(6'd41, 3'd0, $urandom);
        send_load(6'd63, 3'd7, $urandom);
        send_load(6'd2, 3'd6, $urandom);
        send_load(6'd0, 3'd0, 32'hffff_ffff);
        send_load(6'd40, 3'd5, 32'h0000_0000);
    endtask

    // warm-up, field extremes and each mode band
    task automatic test_directed();
        write_car_coefs(32'h0000_0000);
        send_speed(0);
        send_speed(0);
        send_speed(16'sh7fff);
        send_speed(-32768);
        send_speed(0);
        send_speed(0);
        send_speed(0);
        send_speed(128);
        send_speed(5 * 256);
        send_speed(10 * 256);
        send_speed(12 * 256);
        send_speed(20 * 256);
        send_speed(30 * 256);
        send_speed(32 * 256);
        send_speed(35 * 256);
        send_speed(-5 * 256);
        send_speed(-10 * 256);
        send_speed(-10 * 256);
        // sustained braking at 2 m/s per second
        for (int k = 0; k < 6; k++) send_speed((20 - 2 * k) * 256);
    endtask

    // one random drive cycle sample: mostly a smooth walk, some noise, now and then a table load
    task automatic send_random_speed();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_speed($urandom_range(0, 65535) - 32768);
        end else begin
            if (pick < 16) walk_speed -= $urandom_range(300, 800);
            else walk_speed += $urandom_range(0, 1536) - 768;
            if (walk_speed < 0) walk_speed = $urandom_range(0, 300);
            if (walk_speed > 40 * 256) walk_speed = 40 * 256 - $urandom_range(0, 500);
            send_speed(walk_speed);
        end
        if ($urandom_range(0, 29) == 0)
            send_load(6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)), $urandom);
    endtask

    task automatic test_random_phase(int count);
        for (int n = 0; n < count; n++) send_random_speed();
    endtask

    // sweep of register settings, extremes among them
    task automatic test_config_sweep();
        tx_idle_pct = 28;
        rx_idle_pct = 88;
        write_car_coefs(32'hfd00_0000);
        test_random_phase(250);
        write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        test_random_phase(60);
        write_all(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
        test_random_phase(100);
        tx_idle_pct = 88;
        rx_idle_pct = 28;
        write_all(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000);
        test_random_phase(100);
        write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        test_random_phase(150);
        write_car_coefs(32'h0050_0000);
        test_random_phase(250);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_all($urandom_range(0, 32'h00ff_ffff), $urandom_range(0, 32'h000f_ffff),
                  $urandom_range(0, 32'h0000_ffff), $urandom_range(0, 32'h03ff_ffff),
                  $urandom_range(0, 32'h01ff_ffff),
                  $urandom_range(0, 32'h01ff_ffff) - 32'h0100_0000);
        test_random_phase(300);
        write_car_coefs(32'h0000_0000);
        test_random_phase(300);
    endtask

    initial begin
        warm_count = 0;
        speed_win = '{0, 0};
        accel_hist = '{0, 0};
        coef = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0100_0000, 32'h0};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        tx_idle_pct = 28;
        rx_idle_pct = 88;
        test_table_load();
        test_directed();
        test_config_sweep();
        wait_idle();
        if (errors == 0) begin
            $display("vsp_opmode_emission_rate_core regression: pass");
        end else begin
            $display("vsp_opmode_emission_rate_core regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/vsp_pkg.sv
rtl/vsp_opmode_emission_rate_core.sv
dv/vsp_opmode_emission_rate_core_tb.sv
